// ===== hdl/vcs_pkg.sv =====
// ----------------------------------------------------------------------------
// vcs_pkg
// Shared widths, constants and the pipeline type of the velocity command
// saturation block.
// ----------------------------------------------------------------------------
package vcs_pkg;

  localparam int VEL_WIDTH  = 24;
  localparam int LIM_W      = VEL_WIDTH - 1;
  localparam int MAG_W      = VEL_WIDTH;
  localparam int RATIO_FRAC = 32;
  localparam int RATIO_W    = RATIO_FRAC + 1;
  localparam int DIV_LAT    = RATIO_FRAC;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int ROOT_W     = MAG_W;
  localparam int SQRT_LAT   = ROOT_W;
  localparam int PROD_W     = MAG_W + RATIO_W;
  localparam int CFG_IDX_W  = 3;

  localparam logic [RATIO_W-1:0] RATIO_ONE = {1'b1, {RATIO_FRAC{1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_MAX_FORWARD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STRAFE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PLANAR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TURN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BACKWARD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_MODE    = 3'd5;

  typedef struct packed {
    logic             valid;
    logic             neg_x;
    logic             neg_y;
    logic             neg_w;
    logic [MAG_W-1:0] mx;
    logic [MAG_W-1:0] my;
    logic [MAG_W-1:0] mw;
    logic             ox;
    logic             oy;
    logic             ow;
    logic             inv;
    logic             over;
    logic             eq;
  } pipe_t;

endpackage

// ===== hdl/vcs_div.sv =====
// ----------------------------------------------------------------------------
// vcs_div
// Pipelined restoring divider, one quotient bit per stage. Computes
// floor(num * 2^32 / den) for num < den.
// ----------------------------------------------------------------------------
module vcs_div (
  input  logic                            clk,
  input  logic                            en,
  input  logic [vcs_pkg::LIM_W-1:0]       num,
  input  logic [vcs_pkg::MAG_W-1:0]       den,
  output logic [vcs_pkg::RATIO_FRAC-1:0]  quo
);

  logic [vcs_pkg::MAG_W-1:0]      rem_r [vcs_pkg::DIV_LAT];
  logic [vcs_pkg::MAG_W-1:0]      den_r [vcs_pkg::DIV_LAT];
  logic [vcs_pkg::RATIO_FRAC-1:0] q_r   [vcs_pkg::DIV_LAT];

  for (genvar g = 0; g < vcs_pkg::DIV_LAT; g++) begin : g_stage
    logic [vcs_pkg::MAG_W-1:0]      rem_in;
    logic [vcs_pkg::MAG_W-1:0]      den_in;
    logic [vcs_pkg::RATIO_FRAC-1:0] q_in;
    logic [vcs_pkg::MAG_W:0]        trial;
    logic                           ge;
    logic [vcs_pkg::MAG_W-1:0]      rem_nxt;

    if (g == 0) begin : g_first
      assign rem_in = vcs_pkg::MAG_W'(num);
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_rest
      assign rem_in = rem_r[g-1];
      assign den_in = den_r[g-1];
      assign q_in   = q_r[g-1];
    end

    assign trial   = {rem_in, 1'b0};
    assign ge      = trial >= {1'b0, den_in};
    assign rem_nxt = ge ? vcs_pkg::MAG_W'(trial - {1'b0, den_in})
                        : trial[vcs_pkg::MAG_W-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= rem_nxt;
        den_r[g] <= den_in;
        q_r[g]   <= {q_in[vcs_pkg::RATIO_FRAC-2:0], ge};
      end
    end
  end

  assign quo = q_r[vcs_pkg::DIV_LAT-1];

endmodule

// ===== hdl/vcs_sqrt.sv =====
// ----------------------------------------------------------------------------
// vcs_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module vcs_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [vcs_pkg::SQ_W-1:0]    x,
  output logic [vcs_pkg::ROOT_W-1:0]  root
);

  logic [vcs_pkg::SQ_W-1:0]     x_r    [vcs_pkg::SQRT_LAT];
  logic [vcs_pkg::ROOT_W+1:0]   rem_r  [vcs_pkg::SQRT_LAT];
  logic [vcs_pkg::ROOT_W-1:0]   root_r [vcs_pkg::SQRT_LAT];

  for (genvar g = 0; g < vcs_pkg::SQRT_LAT; g++) begin : g_stage
    logic [vcs_pkg::SQ_W-1:0]   x_in;
    logic [vcs_pkg::ROOT_W+1:0] rem_in;
    logic [vcs_pkg::ROOT_W-1:0] root_in;
    logic [vcs_pkg::ROOT_W+3:0] cur;
    logic [vcs_pkg::ROOT_W+3:0] trial;
    logic                       ge;

    if (g == 0) begin : g_first
      assign x_in    = x;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_rest
      assign x_in    = x_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
    end

    assign cur   = {rem_in, x_in[vcs_pkg::SQ_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[g]    <= {x_in[vcs_pkg::SQ_W-3:0], 2'b00};
        rem_r[g]  <= ge ? (vcs_pkg::ROOT_W+2)'(cur - trial) : cur[vcs_pkg::ROOT_W+1:0];
        root_r[g] <= {root_in[vcs_pkg::ROOT_W-2:0], ge};
      end
    end
  end

  assign root = root_r[vcs_pkg::SQRT_LAT-1];

endmodule

// ===== hdl/velocity_command_saturation_top.sv =====
// ----------------------------------------------------------------------------
// velocity_command_saturation_top
// Limits a planar velocity command per axis and then on planar speed.
// ----------------------------------------------------------------------------
// The block takes one command per clock while no valid result is stalled
// at the output and passes it through one input stage, 32-stage ratio
// dividers, scale, square and sum stages, a 24-stage square root, a second
// 32-stage divider for the planar ratio, a final scale stage and the output
// register, the bit-per-stage dividers and root making up most of them.
// When a valid result is stalled the whole pipeline holds and in_stall
// rises. Configuration is written through cfg_valid/cfg_ready, always
// ready, and must only change while no item is in flight.
module velocity_command_saturation_top (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [vcs_pkg::VEL_WIDTH-1:0] in_vel_forward,
  input  logic signed [vcs_pkg::VEL_WIDTH-1:0] in_vel_lateral,
  input  logic signed [vcs_pkg::VEL_WIDTH-1:0] in_turn_rate,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [vcs_pkg::VEL_WIDTH-1:0] out_sat_forward,
  output logic signed [vcs_pkg::VEL_WIDTH-1:0] out_sat_lateral,
  output logic signed [vcs_pkg::VEL_WIDTH-1:0] out_sat_turn_rate,
  output logic                                out_backward_limit_invalid,

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vcs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vcs_pkg::LIM_W-1:0]           cfg_wdata
);

  logic [vcs_pkg::LIM_W-1:0] max_fwd_r, max_str_r, max_pln_r, max_trn_r, max_bwd_r;
  logic                      prop_r;
  logic [2*vcs_pkg::LIM_W-1:0] pln_sq_r;

  logic en;

  vcs_pkg::pipe_t a_r, a_nxt;
  logic [vcs_pkg::LIM_W-1:0] lim_x_r, lim_x_nxt;
  vcs_pkg::pipe_t dl1_r [vcs_pkg::DIV_LAT];
  vcs_pkg::pipe_t b_r, b_nxt;
  vcs_pkg::pipe_t c_r;
  vcs_pkg::pipe_t d_r, d_nxt;
  vcs_pkg::pipe_t dl2_r [vcs_pkg::SQRT_LAT];
  vcs_pkg::pipe_t f_in;
  vcs_pkg::pipe_t dl3_r [vcs_pkg::DIV_LAT];
  vcs_pkg::pipe_t g_r;

  logic [vcs_pkg::SQ_W-1:0] sq_x_r, sq_y_r, sum_r;
  logic [vcs_pkg::SQ_W-1:0] sum_nxt;
  logic [vcs_pkg::MAG_W-1:0] gx_r, gy_r;

  logic [vcs_pkg::RATIO_FRAC-1:0] qx, qy, qw, qp;
  logic [vcs_pkg::ROOT_W-1:0]     root;

  logic                     out_valid_r;
  logic [vcs_pkg::VEL_WIDTH-1:0] out_fwd_r, out_lat_r, out_trn_r;
  logic                     out_inv_r;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_fwd_r <= '0;
      max_str_r <= '0;
      max_pln_r <= '0;
      max_trn_r <= '0;
      max_bwd_r <= '0;
      prop_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vcs_pkg::REG_MAX_FORWARD:  max_fwd_r <= cfg_wdata;
        vcs_pkg::REG_MAX_STRAFE:   max_str_r <= cfg_wdata;
        vcs_pkg::REG_MAX_PLANAR:   max_pln_r <= cfg_wdata;
        vcs_pkg::REG_MAX_TURN:     max_trn_r <= cfg_wdata;
        vcs_pkg::REG_MAX_BACKWARD: max_bwd_r <= cfg_wdata;
        vcs_pkg::REG_PROP_MODE:    prop_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pln_sq_r <= max_pln_r * max_pln_r;
  end

  // input stage: magnitudes and over-limit flags
  always_comb begin
    logic fwd_over;
    logic bwd_over;
    a_nxt       = '0;
    a_nxt.valid = in_valid && en;
    a_nxt.neg_x = in_vel_forward[vcs_pkg::VEL_WIDTH-1];
    a_nxt.neg_y = in_vel_lateral[vcs_pkg::VEL_WIDTH-1];
    a_nxt.neg_w = in_turn_rate[vcs_pkg::VEL_WIDTH-1];
    a_nxt.mx    = a_nxt.neg_x ? vcs_pkg::MAG_W'(-in_vel_forward) : in_vel_forward;
    a_nxt.my    = a_nxt.neg_y ? vcs_pkg::MAG_W'(-in_vel_lateral) : in_vel_lateral;
    a_nxt.mw    = a_nxt.neg_w ? vcs_pkg::MAG_W'(-in_turn_rate) : in_turn_rate;
    fwd_over    = !a_nxt.neg_x && (a_nxt.mx > {1'b0, max_fwd_r});
    bwd_over    = a_nxt.neg_x && (max_bwd_r != '0) && (a_nxt.mx > {1'b0, max_bwd_r});
    a_nxt.ox    = fwd_over || bwd_over;
    a_nxt.oy    = a_nxt.my > {1'b0, max_str_r};
    a_nxt.ow    = a_nxt.mw > {1'b0, max_trn_r};
    a_nxt.inv   = max_bwd_r == '0;
    lim_x_nxt   = fwd_over ? max_fwd_r : max_bwd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
    end else if (en) begin
      a_r     <= a_nxt;
      lim_x_r <= lim_x_nxt;
    end
  end

  vcs_div u_div_x (.clk(clk), .en(en), .num(lim_x_r),   .den(a_r.mx), .quo(qx));
  vcs_div u_div_y (.clk(clk), .en(en), .num(max_str_r), .den(a_r.my), .quo(qy));
  vcs_div u_div_w (.clk(clk), .en(en), .num(max_trn_r), .den(a_r.mw), .quo(qw));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < vcs_pkg::DIV_LAT; i++) dl1_r[i] <= '0;
    end else if (en) begin
      dl1_r[0] <= a_r;
      for (int i = 1; i < vcs_pkg::DIV_LAT; i++) dl1_r[i] <= dl1_r[i-1];
    end
  end

  // per-axis scaling
  always_comb begin
    vcs_pkg::pipe_t         p;
    logic [vcs_pkg::RATIO_W-1:0] rx, ry, rw, rmin;
    logic [vcs_pkg::PROD_W-1:0]  px, py, pw;
    p    = dl1_r[vcs_pkg::DIV_LAT-1];
    rx   = p.ox ? {1'b0, qx} : vcs_pkg::RATIO_ONE;
    ry   = p.oy ? {1'b0, qy} : vcs_pkg::RATIO_ONE;
    rw   = p.ow ? {1'b0, qw} : vcs_pkg::RATIO_ONE;
    rmin = rx;
    if (ry < rmin) rmin = ry;
    if (rw < rmin) rmin = rw;
    if (prop_r) begin
      rx = rmin;
      ry = rmin;
      rw = rmin;
    end
    px = p.mx * rx;
    py = p.my * ry;
    pw = p.mw * rw;
    b_nxt    = p;
    b_nxt.mx = px[vcs_pkg::PROD_W-2 -: vcs_pkg::MAG_W];
    b_nxt.my = py[vcs_pkg::PROD_W-2 -: vcs_pkg::MAG_W];
    b_nxt.mw = pw[vcs_pkg::PROD_W-2 -: vcs_pkg::MAG_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r <= '0;
      c_r <= '0;
      d_r <= '0;
    end else if (en) begin
      b_r <= b_nxt;
      c_r <= b_r;
      d_r <= d_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x_r <= b_r.mx * b_r.mx;
      sq_y_r <= b_r.my * b_r.my;
      sum_r  <= sum_nxt;
    end
  end

  always_comb begin
    sum_nxt    = sq_x_r + sq_y_r;
    d_nxt      = c_r;
    d_nxt.over = sum_nxt > vcs_pkg::SQ_W'(pln_sq_r);
  end

  vcs_sqrt u_sqrt (.clk(clk), .en(en), .x(sum_r), .root(root));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < vcs_pkg::SQRT_LAT; i++) dl2_r[i] <= '0;
    end else if (en) begin
      dl2_r[0] <= d_r;
      for (int i = 1; i < vcs_pkg::SQRT_LAT; i++) dl2_r[i] <= dl2_r[i-1];
    end
  end

  always_comb begin
    f_in    = dl2_r[vcs_pkg::SQRT_LAT-1];
    f_in.eq = root == {1'b0, max_pln_r};
  end

  vcs_div u_div_p (.clk(clk), .en(en), .num(max_pln_r), .den(root), .quo(qp));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < vcs_pkg::DIV_LAT; i++) dl3_r[i] <= '0;
    end else if (en) begin
      dl3_r[0] <= f_in;
      for (int i = 1; i < vcs_pkg::DIV_LAT; i++) dl3_r[i] <= dl3_r[i-1];
    end
  end

  // planar scaling
  logic [vcs_pkg::RATIO_W-1:0] rp;
  logic [vcs_pkg::PROD_W-1:0]  ppx, ppy;
  vcs_pkg::pipe_t              h;

  always_comb begin
    h   = dl3_r[vcs_pkg::DIV_LAT-1];
    rp  = (h.over && !h.eq) ? {1'b0, qp} : vcs_pkg::RATIO_ONE;
    ppx = h.mx * rp;
    ppy = h.my * rp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_r <= '0;
    end else if (en) begin
      g_r <= h;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gx_r <= ppx[vcs_pkg::PROD_W-2 -: vcs_pkg::MAG_W];
      gy_r <= ppy[vcs_pkg::PROD_W-2 -: vcs_pkg::MAG_W];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= g_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_fwd_r <= g_r.neg_x ? vcs_pkg::VEL_WIDTH'(-gx_r) : gx_r;
      out_lat_r <= g_r.neg_y ? vcs_pkg::VEL_WIDTH'(-gy_r) : gy_r;
      out_trn_r <= g_r.neg_w ? vcs_pkg::VEL_WIDTH'(-g_r.mw) : g_r.mw;
      out_inv_r <= g_r.inv;
    end
  end

  assign out_valid                  = out_valid_r;
  assign out_sat_forward            = out_fwd_r;
  assign out_sat_lateral            = out_lat_r;
  assign out_sat_turn_rate          = out_trn_r;
  assign out_backward_limit_invalid = out_inv_r;

`ifndef SYNTHESIS
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r)
    else $error("result dropped while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall)
    else $error("input stalled without output backpressure");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid_r && !a_r.valid)
    else $error("pipeline not empty after reset");

  a_planar_eq: assert property (@(posedge clk) disable iff (!rst_n)
    en && f_in.valid && f_in.over |-> root >= {1'b0, max_pln_r})
    else $error("planar root below limit");
`endif

endmodule
